// ===== hdl/rspe_pkg.sv =====
// Shared constants, types and GF(2^8) functions of the Reed-Solomon parity encoder.
`default_nettype none
package rspe_pkg;

	localparam int PARITY_BYTES = 32;
	localparam int CODE_LEN = 255;
	localparam logic [7:0] DATA_LEN = 8'(CODE_LEN - PARITY_BYTES);
	localparam logic [8:0] FIELD_POLY = 9'h11D;
	localparam int EMIT_W = $clog2(PARITY_BYTES);

	typedef logic [7:0] gen_t [0:PARITY_BYTES];

	typedef struct packed {
		logic absorb;
		logic zero_feed;
		logic shift;
	} dp_cmd_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [8:0] a;
		logic [7:0] r;
		a = {1'b0, x};
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (y[i]) begin
				r = r ^ a[7:0];
			end
			a = a << 1;
			if (a[8]) begin
				a = a ^ FIELD_POLY;
			end
		end
		return r;
	endfunction

	function automatic gen_t build_gen();
		gen_t g;
		logic [7:0] root;
		for (int k = 0; k <= PARITY_BYTES; k++) begin
			g[k] = 8'h00;
		end
		g[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < PARITY_BYTES; i++) begin
			g[i + 1] = 8'h01;
			for (int j = i; j > 0; j--) begin
				g[j] = g[j - 1] ^ gf_mul(g[j], root);
			end
			g[0] = gf_mul(g[0], root);
			root = gf_mul(root, 8'h02);
		end
		return g;
	endfunction

	localparam gen_t GEN = build_gen();

endpackage
`default_nettype wire

// ===== hdl/rspe_in_if.sv =====
// Request channel carrying message bytes into the encoder.
`default_nettype none
interface rspe_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink (input valid, input data_byte, input block_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/rspe_out_if.sv =====
// Request channel carrying parity bytes out of the encoder.
`default_nettype none
interface rspe_out_if;
	logic valid;
	logic ready;
	logic [7:0] parity_byte;
	logic [4:0] parity_index;
	logic parity_last;

	modport source (output valid, output parity_byte, output parity_index,
		output parity_last, input ready);
	modport sink (input valid, input parity_byte, input parity_index,
		input parity_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/rspe_ctrl.sv =====
// Controller state machine: absorbs bytes, pads short blocks and sequences parity output.
`default_nettype none
module rspe_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                block_end,
	output logic                     in_ready,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic [4:0]               parity_index,
	output logic                     parity_last,
	output rspe_pkg::dp_cmd_t        cmd
);
	typedef enum logic [2:0] {
		ST_ABSORB = 3'b001,
		ST_PAD    = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t state_q;
	logic [7:0] cnt_q;
	logic [rspe_pkg::EMIT_W-1:0] emit_q;
	logic [7:0] cnt_inc;
	logic in_acc;
	logic emit_end;

	assign in_ready = (state_q == ST_ABSORB);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc = in_ready & in_valid;
	assign cnt_inc = cnt_q + 8'd1;
	assign emit_end = (emit_q == rspe_pkg::EMIT_W'(rspe_pkg::PARITY_BYTES - 1));
	assign parity_index = 5'(emit_q);
	assign parity_last = emit_end;

	always_comb begin
		cmd.absorb = in_acc | (state_q == ST_PAD);
		cmd.zero_feed = (state_q == ST_PAD);
		cmd.shift = (state_q == ST_EMIT) & out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			cnt_q <= 8'd0;
			emit_q <= '0;
		end else begin
			unique case (state_q)
				ST_ABSORB: begin
					if (in_acc) begin
						if (cnt_inc == rspe_pkg::DATA_LEN) begin
							cnt_q <= 8'd0;
							state_q <= ST_EMIT;
						end else begin
							cnt_q <= cnt_inc;
							if (block_end) begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_PAD: begin
					if (cnt_inc == rspe_pkg::DATA_LEN) begin
						cnt_q <= 8'd0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (emit_end) begin
							emit_q <= '0;
							state_q <= ST_ABSORB;
						end else begin
							emit_q <= emit_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_ABSORB;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rspe_lfsr.sv =====
// Datapath: parity division shift register with constant GF(2^8) generator taps.
`default_nettype none
module rspe_lfsr (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rspe_pkg::dp_cmd_t cmd,
	input  wire logic [7:0]        data_byte,
	output logic [7:0]             head
);
	localparam int P = rspe_pkg::PARITY_BYTES;

	logic [7:0] par_q [0:P-1];
	logic [7:0] par_d [0:P-1];
	logic [7:0] fb;

	assign head = par_q[0];
	assign fb = (cmd.zero_feed ? 8'h00 : data_byte) ^ par_q[0];

	always_comb begin
		for (int j = 0; j < P; j++) begin
			par_d[j] = par_q[j];
		end
		if (cmd.absorb) begin
			for (int j = 0; j < P - 1; j++) begin
				par_d[j] = par_q[j + 1] ^ rspe_pkg::gf_mul(fb, rspe_pkg::GEN[P - 1 - j]);
			end
			par_d[P - 1] = rspe_pkg::gf_mul(fb, rspe_pkg::GEN[0]);
		end else if (cmd.shift) begin
			for (int j = 0; j < P - 1; j++) begin
				par_d[j] = par_q[j + 1];
			end
			par_d[P - 1] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < P; j++) begin
				par_q[j] <= 8'h00;
			end
		end else begin
			for (int j = 0; j < P; j++) begin
				par_q[j] <= par_d[j];
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/reed_solomon_parity_encoder_top.sv =====
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8).
//
//   Channel   Role   Payload
//   msg       sink   data_byte[7:0], block_end
//   parity    source parity_byte[7:0], parity_index[4:0], parity_last
//
// Each message byte is absorbed into the parity shift register as it is accepted.
// A short block is then padded with zero bytes up to 255 - PARITY_BYTES message bytes.
// The PARITY_BYTES parity bytes follow, one per cycle in which parity.ready is high.
// No message byte is taken during padding or parity output; reset clears all state at once.
`default_nettype none
module reed_solomon_parity_encoder_top (
	input wire logic  clk,
	input wire logic  arst_n,
	rspe_in_if.sink   msg,
	rspe_out_if.source parity
);
	rspe_pkg::dp_cmd_t cmd;
	logic [7:0] head;

	rspe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (msg.valid),
		.block_end    (msg.block_end),
		.in_ready     (msg.ready),
		.out_ready    (parity.ready),
		.out_valid    (parity.valid),
		.parity_index (parity.parity_index),
		.parity_last  (parity.parity_last),
		.cmd          (cmd)
	);

	rspe_lfsr u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (msg.data_byte),
		.head      (head)
	);

	assign parity.parity_byte = head;
endmodule
`default_nettype wire

// ===== hdl/rspe_checker.sv =====
// Port-level checker for the parity encoder, bound to the top level.
`default_nettype none
module rspe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_block_end,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("Parity request changed while stalled.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Message byte accepted during parity output.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("Parity run broken before its last byte.");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid && in_ready)
		else $error("Encoder did not return to message input after the parity run.");

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_block_end |=> !in_ready)
		else $error("Message byte accepted straight after a block end.");
endmodule

bind reed_solomon_parity_encoder_top rspe_checker u_rspe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (msg.valid),
	.in_ready     (msg.ready),
	.in_block_end (msg.block_end),
	.out_valid    (parity.valid),
	.out_ready    (parity.ready),
	.out_byte     (parity.parity_byte),
	.out_last     (parity.parity_last)
);
`default_nettype wire
